// ===== design/assert_macros.svh =====
// Assertion helpers used by the command engine top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/cpce_pkg.sv =====
`timescale 1ns / 1ps

package cpce_pkg;

  localparam int BLOCK_BYTES = 32;
  localparam int BLOCK_WORDS = BLOCK_BYTES / 8;
  localparam int HDR_WORDS   = 34;

  localparam logic [15:0] DEV_TYPE_PRESENT = 16'h0500;
  localparam logic [15:0] ADDR_ALT_CHECK   = 16'h8001;
  localparam logic [15:0] ADDR_BLOCK_MASK  = 16'hFFE0;
  localparam logic [7:0]  CRC_POLY         = 8'h85;
  localparam logic [63:0] FMT_FILL         = 64'h0003000300030003;

  localparam logic [7:0] CFG_PORT_PRESENT = 8'd0;
  localparam logic [7:0] CFG_PACK_FITTED  = 8'd1;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WRITE = 2'd3
  } action_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WR    = 7'b0000100,
    ST_RA    = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_CRC   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  localparam logic [63:0] FMT_HDR [HDR_WORDS] = '{
    64'h8101020304050607, 64'h08090a0b0c0d0e0f,
    64'h1011121314151617, 64'h18191a1b1c1d1e1f,
    64'hffffffff051a5f13, 64'h0000000000000000,
    64'hffffffffffffffff, 64'hffff01ff662599cd,
    64'h0000000000000000, 64'h0000000000000000,
    64'h0000000000000000, 64'h0000000000000000,
    64'hffffffff051a5f13, 64'h0000000000000000,
    64'hffffffffffffffff, 64'hffff01ff662599cd,
    64'hffffffff051a5f13, 64'h0000000000000000,
    64'hffffffffffffffff, 64'hffff01ff662599cd,
    64'h0000000000000000, 64'h0000000000000000,
    64'h0000000000000000, 64'h0000000000000000,
    64'hffffffff051a5f13, 64'h0000000000000000,
    64'hffffffffffffffff, 64'hffff01ff662599cd,
    64'h0000000000000000, 64'h0000000000000000,
    64'h0000000000000000, 64'h0000000000000000,
    64'h0071000300030003, 64'h0003000300030003
  };

  // Shifts one byte, MSB first, through the CRC-8 register.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] c;
    logic [7:0] tap;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      tap = c[7] ? CRC_POLY : 8'h00;
      c = {c[6:0], din[7 - k]} ^ tap;
    end
    return c;
  endfunction

endpackage

// ===== design/controller_pak_command_engine_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Controller pack command engine.
// Commands arrive on the in_valid/in_ready channel, one transfer per command, and
// each command gives exactly one result transfer on out_valid/out_ready.
// The cfg_valid/cfg_ready channel writes the port-present mask (index 0) and the
// pack-fitted mask (index 1); other indexes are ignored. cfg_ready is always high.
// The pack store is one 64-bit-wide memory with one port, PORT_COUNT*PACK_BYTES/8
// rows. A pack write writes the 4 block rows in turn; a pack read gives each row
// an address state, then a registered-data state. The CRC runs one byte per cycle
// over 32 data bytes and one flush byte.
// The block works on one command at a time; in_ready is low while it is busy.
// A finished result waits in the output register while the next command may be
// accepted and processed; that command holds before loading its result until
// the waiting one is taken, so a stalled receiver stops the engine.
// After reset the engine writes the formatted empty pack image into every row,
// one row per cycle (16384 rows at the defaults), with in_ready low.
// Configuration writes are taken during that pass.
module controller_pak_command_engine_top #(
  parameter int PACK_BYTES = 32768,
  parameter int PORT_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  port,
  input  logic        rx_error_in,
  input  logic [15:0] pack_address,
  input  logic [63:0] data_word0,
  input  logic [63:0] data_word1,
  input  logic [63:0] data_word2,
  input  logic [63:0] data_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] device_type,
  output logic        pack_inserted,
  output logic        no_device,
  output logic [63:0] block_word0,
  output logic [63:0] block_word1,
  output logic [63:0] block_word2,
  output logic [63:0] block_word3,
  output logic [7:0]  block_crc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import cpce_pkg::*;

  localparam int PACK_WORDS = PACK_BYTES / 8;
  localparam int MEM_ROWS   = PORT_COUNT * PACK_WORDS;
  localparam int ROW_W      = $clog2(MEM_ROWS);
  localparam int WORD_W     = $clog2(PACK_WORDS);

  state_t state;
  state_t state_next;

  logic [3:0] present_mask;
  logic [3:0] fitted_mask;

  logic [63:0] mem [MEM_ROWS];
  logic [63:0] mem_q;
  logic        mem_we;
  logic [ROW_W-1:0] mem_addr;
  logic [63:0] mem_wdata;

  logic [ROW_W-1:0]  clr_row;
  logic [WORD_W-1:0] clr_word;
  logic [63:0]       fmt_word;
  logic              clr_last;

  logic [63:0] blk [BLOCK_WORDS];
  logic [1:0]  wk;
  logic [5:0]  cnt;
  logic [7:0]  crc;
  logic [7:0]  crc_din;
  logic [ROW_W-1:0] row0;
  logic [1:0]  act_q;
  logic [15:0] dev_q;
  logic        ins_q;
  logic        nodev_q;

  logic        accept;
  logic        port_ok;
  logic        present;
  logic        fitted;
  logic        in_pack;
  logic [16:0] blk_end;
  logic [31:0] row_calc;
  logic        do_write;
  logic        do_read;
  logic        do_crc;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign port_ok  = 3'(port) < 3'(PORT_COUNT);
  assign present  = port_ok && present_mask[port];
  assign fitted   = port_ok && fitted_mask[port];
  assign blk_end  = 17'(pack_address & ADDR_BLOCK_MASK) + 17'(BLOCK_BYTES);
  assign in_pack  = (pack_address != ADDR_ALT_CHECK) && (blk_end <= 17'(PACK_BYTES));
  assign row_calc = 32'(port) * 32'(PACK_WORDS) + 32'(pack_address[15:5]) * 32'(BLOCK_WORDS);

  assign do_write = (action == ACT_WRITE) && present && fitted && in_pack;
  assign do_read  = (action == ACT_READ) && present && fitted && in_pack;
  assign do_crc   = ((action == ACT_READ) && present && fitted)
                 || ((action == ACT_WRITE) && present);

  assign clr_last = (clr_row == ROW_W'(MEM_ROWS - 1));
  assign fmt_word = (clr_word < WORD_W'(HDR_WORDS)) ? FMT_HDR[clr_word[5:0]] : FMT_FILL;

  assign mem_we    = (state == ST_CLEAR) || (state == ST_WR);
  assign mem_addr  = (state == ST_CLEAR) ? clr_row : row0 + ROW_W'(wk);
  assign mem_wdata = (state == ST_CLEAR) ? fmt_word : blk[wk];

  assign crc_din = cnt[5] ? 8'h00 : blk[cnt[4:3]][{3'd7 - cnt[2:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (do_write)    state_next = ST_WR;
          else if (do_read) state_next = ST_RA;
          else if (do_crc)  state_next = ST_CRC;
          else              state_next = ST_FIN;
        end
      end
      ST_WR: begin
        if (wk == 2'd3) state_next = ST_CRC;
      end
      ST_RA: state_next = ST_RD;
      ST_RD: begin
        state_next = (wk == 2'd3) ? ST_CRC : ST_RA;
      end
      ST_CRC: begin
        if (cnt == 6'(BLOCK_BYTES)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      present_mask <= 4'd1;
      fitted_mask  <= 4'd1;
      clr_row      <= '0;
      clr_word     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PORT_PRESENT: present_mask <= cfg_data;
          CFG_PACK_FITTED:  fitted_mask  <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_row  <= clr_row + ROW_W'(1);
        clr_word <= (clr_word == WORD_W'(PACK_WORDS - 1)) ? '0 : clr_word + WORD_W'(1);
      end
      if (state == ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          act_q   <= action;
          row0    <= ROW_W'(row_calc);
          wk      <= 2'd0;
          cnt     <= 6'd0;
          crc     <= 8'h00;
          dev_q   <= 16'h0000;
          ins_q   <= 1'b0;
          nodev_q <= 1'b0;
          if (action == ACT_CHECK) begin
            if (!rx_error_in) begin
              dev_q   <= present ? DEV_TYPE_PRESENT : 16'h0000;
              ins_q   <= present && fitted;
              nodev_q <= !present;
            end
          end else begin
            nodev_q <= !present;
          end
          if ((action == ACT_WRITE) && present) begin
            blk[0] <= data_word0;
            blk[1] <= data_word1;
            blk[2] <= data_word2;
            blk[3] <= data_word3;
          end else begin
            for (int i = 0; i < BLOCK_WORDS; i++) blk[i] <= 64'h0;
          end
        end
      end
      ST_WR: wk <= wk + 2'd1;
      ST_RD: begin
        blk[wk] <= mem_q;
        wk      <= wk + 2'd1;
      end
      ST_CRC: begin
        crc <= crc8_byte(crc, crc_din);
        cnt <= cnt + 6'd1;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          device_type   <= dev_q;
          pack_inserted <= ins_q;
          no_device     <= nodev_q;
          block_word0   <= blk[0];
          block_word1   <= blk[1];
          block_word2   <= blk[2];
          block_word3   <= blk[3];
          block_crc     <= crc;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK_RST(a_reset_clears, rst |=> (state == ST_CLEAR), "reset did not start the clearing pass")
  `ASSERT_CLK(a_no_accept_clear, (state == ST_CLEAR) |-> !in_ready, "command taken during clearing")
  `ASSERT_CLK(a_write_action, (state == ST_WR) |-> (act_q == ACT_WRITE), "store written by a non-write")
  `ASSERT_CLK(a_read_action, (state == ST_RA) |-> (act_q == ACT_READ), "store read by a non-read")
  `ASSERT_CLK(a_crc_count, (state == ST_CRC) |-> (cnt <= 6'(BLOCK_BYTES)), "CRC ran past the flush byte")
  `ASSERT_CLK(a_check_reply, (out_valid && (device_type != 16'h0000)) |-> ((block_crc == 8'h00) && !no_device), "check reply carries block data")

endmodule
